// ----- design/nwpc_pkg.sv -----
// shared types, constants and register indexes for the navigation word parity checker
// no dependencies; used by nwpc_parity_core and nav_word_parity_checker_unit
package nwpc_pkg;

  localparam int WORD_W    = 30;
  localparam int DATA_W    = 24;
  localparam int PAR_W     = 6;
  localparam int HIST_W    = 2;
  localparam int PRE_W     = 8;
  localparam int ID_W      = 3;
  localparam int COUNT_W   = 4;
  localparam int NUM_MASKS = 6;
  localparam int CFG_IDX_W = 3;

  localparam int SUBFRAME_WORDS_DEF = 10;

  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [PAR_W-1:0]   par_t;
  typedef logic [HIST_W-1:0]  hist_t;
  typedef logic [PRE_W-1:0]   pre_t;
  typedef logic [ID_W-1:0]    id_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef data_t mask_set_t [NUM_MASKS];

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASK_P25 = 3'd0,
    REG_MASK_P26 = 3'd1,
    REG_MASK_P27 = 3'd2,
    REG_MASK_P28 = 3'd3,
    REG_MASK_P29 = 3'd4,
    REG_MASK_P30 = 3'd5,
    REG_PREAMBLE = 3'd6
  } cfg_reg_t;

  localparam data_t MASK_P25_RST = 24'hEC7CD2;
  localparam data_t MASK_P26_RST = 24'h763E69;
  localparam data_t MASK_P27_RST = 24'hBB1F34;
  localparam data_t MASK_P28_RST = 24'h5D8F9A;
  localparam data_t MASK_P29_RST = 24'hAEC7CD;
  localparam data_t MASK_P30_RST = 24'h2DEA27;
  localparam pre_t  PREAMBLE_RST = 8'h8B;

endpackage

// ----- design/nwpc_parity_core.sv -----
// parity generator for one 30-bit word: polarity correction and six masked xor trees
// depends on nwpc_pkg
module nwpc_parity_core (
  input  nwpc_pkg::word_t     word,
  input  nwpc_pkg::hist_t     hist,
  input  nwpc_pkg::mask_set_t masks,
  output nwpc_pkg::par_t      parity,
  output nwpc_pkg::data_t     data
);
  import nwpc_pkg::*;

  logic d29;
  logic d30;

  assign d29 = hist[1];
  assign d30 = hist[0];

  // previous d30 set means the data arrives inverted
  assign data = d30 ? ~word[WORD_W-1:PAR_W] : word[WORD_W-1:PAR_W];

  assign parity[5] = d29 ^ (^(data & masks[0]));
  assign parity[4] = d30 ^ (^(data & masks[1]));
  assign parity[3] = d29 ^ (^(data & masks[2]));
  assign parity[2] = d30 ^ (^(data & masks[3]));
  assign parity[1] = d30 ^ (^(data & masks[4]));
  assign parity[0] = d29 ^ (^(data & masks[5]));

endmodule

// ----- design/nav_word_parity_checker_unit.sv -----
// Navigation word parity checker, top level. Takes one 30-bit word per cycle while
// in_stall is low and returns one result per accepted word: the word sits in an input
// register, the parity xor trees, preamble tests and subframe counter are combinational
// after it, and the result lands in an output register. Throughput is one item per clock
// while the output side takes results; the output register and input register let a new
// item enter while a finished result still waits.
// depends on nwpc_pkg and nwpc_parity_core
module nav_word_parity_checker_unit #(
  parameter int SUBFRAME_WORDS = nwpc_pkg::SUBFRAME_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // input items
  input  logic                in_valid,
  output logic                in_stall,
  input  nwpc_pkg::word_t     rx_word,
  input  logic                start_subframe,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  nwpc_pkg::cfg_idx_t  cfg_index,
  input  nwpc_pkg::data_t     cfg_data,
  // result items
  output logic                out_valid,
  input  logic                out_stall,
  output nwpc_pkg::data_t     data_bits,
  output logic                word_ok,
  output logic                tlm_hit,
  output logic                tlm_inverted,
  output logic                subframe_done,
  output logic                subframe_ok,
  output nwpc_pkg::id_t       subframe_number
);
  import nwpc_pkg::*;

  localparam count_t LAST_COUNT = COUNT_W'(SUBFRAME_WORDS);

  // configuration registers
  mask_set_t masks;
  pre_t      preamble;

  // input register
  logic  s1_valid;
  word_t s1_word;
  logic  s1_start;

  // subframe state
  hist_t  prev_parity;
  count_t word_count;
  logic   sticky_error;
  id_t    captured_id;

  hist_t  prev_parity_next;
  count_t word_count_next;
  logic   sticky_error_next;
  id_t    captured_id_next;

  logic s1_fire;
  logic in_take;

  hist_t  hist_cur;
  count_t count_cur;
  logic   sticky_cur;
  id_t    id_cur;
  count_t count_inc;

  par_t  par_hist;
  data_t data_hist;
  par_t  par_up;
  data_t data_up;
  par_t  par_inv;
  data_t data_inv;
  word_t word_inv;

  logic ok;
  logic up_ok;
  logic inv_ok;
  logic hit;
  logic inv;
  logic done;
  logic sf_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      masks[0] <= MASK_P25_RST;
      masks[1] <= MASK_P26_RST;
      masks[2] <= MASK_P27_RST;
      masks[3] <= MASK_P28_RST;
      masks[4] <= MASK_P29_RST;
      masks[5] <= MASK_P30_RST;
      preamble <= PREAMBLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MASK_P25: masks[0] <= cfg_data;
        REG_MASK_P26: masks[1] <= cfg_data;
        REG_MASK_P27: masks[2] <= cfg_data;
        REG_MASK_P28: masks[3] <= cfg_data;
        REG_MASK_P29: masks[4] <= cfg_data;
        REG_MASK_P30: masks[5] <= cfg_data;
        REG_PREAMBLE: preamble <= cfg_data[PRE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: stage 1 moves on when the output register is free or being taken
  assign s1_fire  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_fire;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word  <= rx_word;
      s1_start <= start_subframe;
    end
  end

  // subframe start clears history before this word
  assign hist_cur   = s1_start ? '0 : prev_parity;
  assign count_cur  = s1_start ? '0 : word_count;
  assign sticky_cur = s1_start ? 1'b0 : sticky_error;
  assign id_cur     = s1_start ? '0 : captured_id;

  nwpc_parity_core u_par_hist (
    .word   (s1_word),
    .hist   (hist_cur),
    .masks  (masks),
    .parity (par_hist),
    .data   (data_hist)
  );

  nwpc_parity_core u_par_up (
    .word   (s1_word),
    .hist   ('0),
    .masks  (masks),
    .parity (par_up),
    .data   (data_up)
  );

  assign word_inv = ~s1_word;

  nwpc_parity_core u_par_inv (
    .word   (word_inv),
    .hist   ('0),
    .masks  (masks),
    .parity (par_inv),
    .data   (data_inv)
  );

  assign ok     = (par_hist == s1_word[PAR_W-1:0]);
  assign up_ok  = (par_up == s1_word[PAR_W-1:0]);
  assign inv_ok = (par_inv == word_inv[PAR_W-1:0]);

  // complemented word is only tried when the upright parity fails
  always_comb begin
    if (up_ok) begin
      hit = (data_up[DATA_W-1 -: PRE_W] == preamble);
      inv = 1'b0;
    end else begin
      hit = inv_ok && (data_inv[DATA_W-1 -: PRE_W] == preamble);
      inv = hit;
    end
  end

  assign count_inc = count_cur + count_t'(1);
  assign done      = (count_inc >= LAST_COUNT);

  always_comb begin
    prev_parity_next  = par_hist[HIST_W-1:0];
    sticky_error_next = sticky_cur | ~ok;
    captured_id_next  = (count_cur == count_t'(1)) ? data_hist[4:2] : id_cur;
    word_count_next   = count_inc;
    sf_ok             = 1'b0;
    if (done) begin
      sf_ok             = ~sticky_error_next && (par_hist[HIST_W-1:0] == '0);
      word_count_next   = '0;
      sticky_error_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_parity  <= '0;
      word_count   <= '0;
      sticky_error <= 1'b0;
      captured_id  <= '0;
    end else if (s1_fire) begin
      prev_parity  <= prev_parity_next;
      word_count   <= word_count_next;
      sticky_error <= sticky_error_next;
      captured_id  <= captured_id_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      data_bits       <= data_hist;
      word_ok         <= ok;
      tlm_hit         <= hit;
      tlm_inverted    <= inv;
      subframe_done   <= done;
      subframe_ok     <= sf_ok;
      subframe_number <= captured_id_next;
    end
  end

endmodule
